// ===== sv/alpha_mask_span_extractor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Alpha mask span extractor: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ALPHA_MASK_SPAN_EXTRACTOR_UNIT_DEFINES_SVH
`define ALPHA_MASK_SPAN_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every edge outside reset
`define AMSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("amse check failed");
// implication, consequent checked in the next cycle
`define AMSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("amse check failed");
`else
`define AMSE_ASSERT(lbl, clk, rstn, prop)
`define AMSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/amse_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha mask span extractor package
// Widths, register indexes, result word type and small helpers.
// ----------------------------------------------------------------------------
package amse_pkg;

  localparam int DimW   = 13;
  localparam int CntW   = 16;
  localparam int PixW   = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;

  localparam logic [DimW-1:0] MaxDim = 13'd4096;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAlphaThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegImageHeight    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBatchLimit     = 2'd3;

  // register reset values
  localparam logic [7:0]      ThresholdRst = 8'd32;
  localparam logic [DimW-1:0] WidthRst     = 13'd800;
  localparam logic [DimW-1:0] HeightRst    = 13'd600;
  localparam logic [CntW-1:0] LimitRst     = 16'd2000;

  // result kinds
  localparam logic KindSpan  = 1'b0;
  localparam logic KindBatch = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [DimW-1:0] left;
    logic [DimW-1:0] top;
    logic [DimW-1:0] right;
    logic [DimW-1:0] bottom;
    logic [CntW-1:0] span_count;
    logic            last;
  } amse_result_t;

  // zero acts as one, oversize saturates
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/amse_if.sv =====
// ----------------------------------------------------------------------------
// Alpha mask span extractor channels
// Valid/ready interfaces for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface amse_pixel_if import amse_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface amse_result_if import amse_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [DimW-1:0] left;
  logic [DimW-1:0] top;
  logic [DimW-1:0] right;
  logic [DimW-1:0] bottom;
  logic [CntW-1:0] span_count;
  logic            last;

  modport source (output valid, output kind, output left, output top, output right,
                  output bottom, output span_count, output last, input ready);
  modport sink (input valid, input kind, input left, input top, input right,
                input bottom, input span_count, input last, output ready);
endinterface

interface amse_cfg_if import amse_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/alpha_mask_span_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// Alpha mask span extractor
// Turns a raster pixel stream into opaque run spans and batch bounding boxes.
// ----------------------------------------------------------------------------
// Usage:
//  pix_i  : one 32-bit pixel word per handshake, raster order, alpha in 31:24.
//  res_o  : result words; kind selects span rectangle or batch record, last
//           marks the final word caused by one pixel (up to three words).
//  cfg_i  : register writes (threshold, width, height, batch limit); always
//           ready, write only while the block is idle.
// Timing: a pixel's result words are written to a four-word result queue
//  when the pixel is taken. Span, limit and end-of-image records for one
//  pixel are all worked out together, combinationally, before that write.
// Throughput: one pixel per cycle while the queue holds at most one word;
//  the output drains one word per cycle while the receiver is ready, so
//  pixels producing two or three words hold off the next pixel. The
//  one-word ready threshold and the one-word-per-cycle drain set this figure.
// Reset: registers return to 32/800/600/2000, position, run and batch state
//  clear, the result queue empties.
// Receiver stall: words wait in the queue; once more than one is waiting,
//  pix_i.ready drops until the receiver takes them.
// ----------------------------------------------------------------------------
`include "alpha_mask_span_extractor_unit_defines.svh"

module alpha_mask_span_extractor_unit import amse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  amse_cfg_if.sink      cfg_i,
  amse_pixel_if.sink    pix_i,
  amse_result_if.source res_o
);

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FcntW     = PtrW + 1;

  // ---------------------------------------------------------------- registers
  logic [7:0]      thr_q;
  logic [DimW-1:0] width_q, height_q;
  logic [CntW-1:0] limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThresholdRst;
      width_q  <= WidthRst;
      height_q <= HeightRst;
      limit_q  <= LimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegAlphaThreshold: thr_q    <= cfg_i.data[7:0];
        RegImageWidth:     width_q  <= cfg_i.data[DimW-1:0];
        RegImageHeight:    height_q <= cfg_i.data[DimW-1:0];
        RegBatchLimit:     limit_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- scan state
  logic [DimW-1:0] column_q, column_d, row_q, row_d;
  logic            run_open_q, run_open_d;
  logic [DimW-1:0] run_start_q, run_start_d;
  logic [CntW-1:0] batch_spans_q, batch_spans_d;
  logic [DimW-1:0] box_left_q, box_left_d, box_top_q, box_top_d;
  logic [DimW-1:0] box_right_q, box_right_d, box_bottom_q, box_bottom_d;

  // result queue
  amse_result_t    res_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FcntW-1:0] fifo_cnt_q;

  logic acc, pop;
  assign pix_i.ready = (fifo_cnt_q <= FcntW'(1));
  assign acc = pix_i.valid && pix_i.ready;
  assign pop = res_o.valid && res_o.ready;

  // ---------------------------------------------------------------- per-pixel logic
  logic [DimW-1:0] w, h;
  logic            opaque, row_end, last_row, fin, have_span, hit;
  logic [DimW:0]   col_inc, row_inc;
  logic [DimW-1:0] x0, x1;
  logic            open_eff;
  logic [CntW-1:0] lim, cnt_inc;
  // box/count after the span, then after any limit record
  logic [DimW-1:0] b_left, b_top, b_right, b_bottom;
  logic [CntW-1:0] b_cnt;
  logic [DimW-1:0] p_left, p_top, p_right, p_bottom;
  logic [CntW-1:0] p_cnt;
  amse_result_t    cand [3];
  logic [2:0]      cand_vld;
  amse_result_t    list [3];
  logic [1:0]      n_res;

  always_comb begin
    w        = clamp_dim(width_q);
    h        = clamp_dim(height_q);
    opaque   = pix_i.pixel[31:24] >= thr_q;
    col_inc  = {1'b0, column_q} + 14'd1;
    row_inc  = {1'b0, row_q} + 14'd1;
    row_end  = col_inc >= {1'b0, w};
    last_row = row_inc >= {1'b0, h};
    fin      = row_end && last_row;

    open_eff  = run_open_q || opaque;
    x0        = run_open_q ? run_start_q : column_q;
    x1        = opaque ? col_inc[DimW-1:0] : column_q;
    have_span = open_eff && (!opaque || row_end);

    lim     = (limit_q == '0) ? 16'd1 : limit_q;
    cnt_inc = batch_spans_q + 16'd1;
    hit     = have_span && (cnt_inc >= lim);

    if (have_span) begin
      b_left   = (x0 < box_left_q) ? x0 : box_left_q;
      b_top    = (row_q < box_top_q) ? row_q : box_top_q;
      b_right  = (x1 > box_right_q) ? x1 : box_right_q;
      b_bottom = (row_inc[DimW-1:0] > box_bottom_q) ? row_inc[DimW-1:0] : box_bottom_q;
      b_cnt    = cnt_inc;
    end else begin
      b_left   = box_left_q;
      b_top    = box_top_q;
      b_right  = box_right_q;
      b_bottom = box_bottom_q;
      b_cnt    = batch_spans_q;
    end

    if (hit) begin
      p_left   = MaxDim;
      p_top    = MaxDim;
      p_right  = '0;
      p_bottom = '0;
      p_cnt    = '0;
    end else begin
      p_left   = b_left;
      p_top    = b_top;
      p_right  = b_right;
      p_bottom = b_bottom;
      p_cnt    = b_cnt;
    end

    cand[0] = '{kind: KindSpan, left: x0, top: row_q, right: x1,
                bottom: row_inc[DimW-1:0], span_count: '0, last: !hit && !fin};
    cand[1] = '{kind: KindBatch, left: b_left, top: b_top, right: b_right,
                bottom: b_bottom, span_count: b_cnt, last: !fin};
    cand[2] = '{kind: KindBatch, left: p_left, top: p_top, right: p_right,
                bottom: p_bottom, span_count: p_cnt, last: 1'b1};
    cand_vld = {fin, hit, have_span};

    // pack the valid candidates in order
    n_res = '0;
    list  = cand;
    for (int k = 0; k < 3; k++) begin
      if (cand_vld[k]) begin
        list[n_res] = cand[k];
        n_res       = n_res + 2'd1;
      end
    end

    // next state
    if (fin) begin
      box_left_d    = MaxDim;
      box_top_d     = MaxDim;
      box_right_d   = '0;
      box_bottom_d  = '0;
      batch_spans_d = '0;
    end else begin
      box_left_d    = p_left;
      box_top_d     = p_top;
      box_right_d   = p_right;
      box_bottom_d  = p_bottom;
      batch_spans_d = p_cnt;
    end

    run_open_d  = open_eff && !have_span;
    run_start_d = (opaque && !run_open_q) ? column_q : run_start_q;
    if (row_end) begin
      column_d = '0;
      if (last_row) begin
        row_d       = '0;
        run_open_d  = 1'b0;
        run_start_d = '0;
      end else begin
        row_d = row_inc[DimW-1:0];
      end
    end else begin
      column_d = col_inc[DimW-1:0];
      row_d    = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= '0;
      row_q         <= '0;
      run_open_q    <= 1'b0;
      run_start_q   <= '0;
      batch_spans_q <= '0;
      box_left_q    <= MaxDim;
      box_top_q     <= MaxDim;
      box_right_q   <= '0;
      box_bottom_q  <= '0;
    end else if (acc) begin
      column_q      <= column_d;
      row_q         <= row_d;
      run_open_q    <= run_open_d;
      run_start_q   <= run_start_d;
      batch_spans_q <= batch_spans_d;
      box_left_q    <= box_left_d;
      box_top_q     <= box_top_d;
      box_right_q   <= box_right_d;
      box_bottom_q  <= box_bottom_d;
    end
  end

  // ---------------------------------------------------------------- result queue
  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < n_res) begin
          res_q[wr_ptr_q + PtrW'(k)] <= list[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (acc ? FcntW'(n_res) : FcntW'(0)) - FcntW'(pop);
    end
  end

  amse_result_t head;
  assign head             = res_q[rd_ptr_q];
  assign res_o.valid      = (fifo_cnt_q != '0);
  assign res_o.kind       = head.kind;
  assign res_o.left       = head.left;
  assign res_o.top        = head.top;
  assign res_o.right      = head.right;
  assign res_o.bottom     = head.bottom;
  assign res_o.span_count = head.span_count;
  assign res_o.last       = head.last;

  // ---------------------------------------------------------------- checks
  `AMSE_ASSERT(a_fifo_bound, clk_i, rst_ni, fifo_cnt_q <= FcntW'(FifoDepth))
  `AMSE_ASSERT(a_run_before_col, clk_i, rst_ni, !run_open_q || (run_start_q < column_q))
  `AMSE_ASSERT(a_empty_box, clk_i, rst_ni, (batch_spans_q != '0) || (box_left_q == MaxDim))
  `AMSE_ASSERT_NEXT(a_image_wrap, clk_i, rst_ni, acc && fin, ({row_q, column_q, batch_spans_q} == '0))

endmodule
